@@ design/dsc_pkg.sv @@
// Shared types, state codes and the segment table for the decimal scan driver.
// Used by every module of the block; depends on nothing else.
package dsc_pkg;

   // Fixed field widths
   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned DWELL_W   = 16;
   localparam int unsigned SEG_W     = 8;
   localparam int unsigned SEL_W     = 3;
   localparam int unsigned RSP_DATA_W = 16;

   // Reciprocal of ten scaled by 2^35 (10 * M = 2^35 + 2)
   localparam logic [VALUE_W-1:0] RECIP10 = 32'hCCCC_CCCD;
   localparam int unsigned        RECIP_SHIFT = 35;

   // Input word kinds carried on req_tuser
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Sequencer state codes
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MUL   = 2'd1;
   localparam logic [1:0] ST_DIGIT = 2'd2;
   localparam logic [1:0] ST_SHOW  = 2'd3;

   // Result of one divide-by-ten step
   typedef struct packed {
      logic [VALUE_W-1:0] quot;
      logic [3:0]         digit;
   } div_res_type;

   // Segment code of one decimal digit, bit0 = a .. bit6 = g
   function automatic logic [SEG_W-1:0] seg_of_digit(input logic [3:0] d);
      logic [SEG_W-1:0] s;
      case (d)
         4'd0: s = 8'h3F;
         4'd1: s = 8'h06;
         4'd2: s = 8'h5B;
         4'd3: s = 8'h4F;
         4'd4: s = 8'h66;
         4'd5: s = 8'h6D;
         4'd6: s = 8'h7D;
         4'd7: s = 8'h07;
         4'd8: s = 8'h7F;
         4'd9: s = 8'h6F;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

endpackage

@@ design/dsc_div10.sv @@
// Shared divide-by-ten unit: one registered reciprocal multiply per step.
// Quotient and remainder digit come from the registered product. Uses dsc_pkg.
module dsc_div10 (
   input  logic                          clock,
   input  logic                          start,
   input  logic [dsc_pkg::VALUE_W-1:0]   dividend,
   output dsc_pkg::div_res_type          result
);
   import dsc_pkg::*;

   localparam int unsigned PROD_W = 2 * VALUE_W;

   logic [PROD_W-1:0]        prod_ff;
   logic [PROD_W-1:0]        prod_in;
   logic [RECIP_SHIFT-1:0]   frac;
   logic [RECIP_SHIFT+3:0]   frac_x10;

   // Capture the product when a step starts, hold otherwise
   always_comb begin
      prod_in = prod_ff;
      if (start) begin
         prod_in = PROD_W'(dividend) * PROD_W'(RECIP10);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Quotient is the integer part; the digit is the fraction times ten
   always_comb begin
      frac     = prod_ff[RECIP_SHIFT-1:0];
      frac_x10 = {frac, 3'b000} + {2'b00, frac, 1'b0};
      result.quot  = VALUE_W'(prod_ff[PROD_W-1:RECIP_SHIFT]);
      result.digit = frac_x10[RECIP_SHIFT+3:RECIP_SHIFT];
   end

endmodule

@@ design/dsc_scan.sv @@
// Scan position and dwell counter of the multiplexed display.
// Advances one position after dwell_ticks tick words. Uses dsc_pkg.
module dsc_scan #(
   parameter int unsigned DIGIT_COUNT = 8,
   parameter int unsigned PW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          tick,
   input  logic [dsc_pkg::DWELL_W-1:0]   dwell_ticks,
   output logic [PW-1:0]                 position_next
);
   import dsc_pkg::*;

   localparam logic [PW-1:0] LAST_POS = PW'(DIGIT_COUNT - 1);

   logic [PW-1:0]      pos_ff;
   logic [PW-1:0]      pos_in;
   logic [DWELL_W-1:0] count_ff;
   logic [DWELL_W-1:0] count_in;
   logic [DWELL_W-1:0] limit;
   logic [DWELL_W:0]   count_inc;

   // Count ticks; a dwell of zero acts as one
   always_comb begin
      limit     = (dwell_ticks == '0) ? DWELL_W'(1) : dwell_ticks;
      count_inc = {1'b0, count_ff} + (DWELL_W+1)'(1);
      pos_in    = pos_ff;
      count_in  = count_ff;
      if (tick) begin
         if (count_inc >= {1'b0, limit}) begin
            count_in = '0;
            pos_in   = (pos_ff == LAST_POS) ? '0 : pos_ff + PW'(1);
         end else begin
            count_in = count_inc[DWELL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         count_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         count_ff <= count_in;
      end
   end

   assign position_next = pos_in;

endmodule

@@ design/seven_segment_decimal_scan_top.sv @@
// Tick word: result registered at acceptance; the next word may follow once it is taken.
// Load word: each divide-by-ten step on the shared multiplier runs ST_MUL, then ST_DIGIT;
// digits go right to left until the quotient or the position is zero, then ST_SHOW
// gives one result; no word is accepted meanwhile. dwell_ticks writes apply next cycle.
// Reset (synchronous, active high): store blank, scan position and dwell count zero,
// dwell_ticks one, no result pending.
module seven_segment_decimal_scan_top #(
   parameter int unsigned DIGIT_COUNT = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: value[31:0]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [dsc_pkg::VALUE_W-1:0]        req_tdata,
   // req_tuser: cmd[0]
   input  logic                               req_tuser,
   // rsp_tdata: digit_select[2:0], segments[10:3], zero[15:11]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [dsc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // dwell_ticks register write
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dsc_pkg::DWELL_W-1:0]        csr_data
);
   import dsc_pkg::*;

   localparam int unsigned PW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam logic [PW-1:0] LAST_POS = PW'(DIGIT_COUNT - 1);

   logic [1:0]         state_ff, state_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [PW-1:0]      wpos_ff, wpos_in;
   logic [SEG_W-1:0]   store_ff [DIGIT_COUNT];
   logic [SEG_W-1:0]   store_in [DIGIT_COUNT];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SEL_W-1:0]   rsp_sel_ff, rsp_sel_in;
   logic [SEG_W-1:0]   rsp_seg_ff, rsp_seg_in;
   logic [DWELL_W-1:0] dwell_ff, dwell_in;

   logic               accept;
   logic               tick;
   logic               div_start;
   div_res_type        div_res;
   logic [PW-1:0]      scan_pos;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign tick       = accept && (req_tuser == CMD_TICK);
   assign div_start  = (state_ff == ST_MUL);

   dsc_div10 u_div (
      .clock    (clock),
      .start    (div_start),
      .dividend (value_ff),
      .result   (div_res)
   );

   dsc_scan #(
      .DIGIT_COUNT (DIGIT_COUNT),
      .PW          (PW)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .tick          (tick),
      .dwell_ticks   (dwell_ff),
      .position_next (scan_pos)
   );

   // Hold the dwell register until a write arrives
   always_comb begin
      dwell_in = (csr_valid && csr_ready) ? csr_data : dwell_ff;
   end

   // Sequencer, digit store and result register
   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      wpos_in      = wpos_ff;
      store_in     = store_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_sel_in   = rsp_sel_ff;
      rsp_seg_in   = rsp_seg_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == CMD_TICK) begin
                  rsp_valid_in = 1'b1;
                  rsp_sel_in   = SEL_W'(scan_pos);
                  rsp_seg_in   = store_ff[scan_pos];
               end else begin
                  // Blank the store and start converting from the rightmost position
                  for (int i = 0; i < DIGIT_COUNT; i++) begin
                     store_in[i] = '0;
                  end
                  value_in = req_tdata;
                  wpos_in  = LAST_POS;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            // Write one digit, then stop or step left
            store_in[wpos_ff] = seg_of_digit(div_res.digit);
            value_in          = div_res.quot;
            if (div_res.quot == '0 || wpos_ff == '0) begin
               state_in = ST_SHOW;
            end else begin
               wpos_in  = wpos_ff - PW'(1);
               state_in = ST_MUL;
            end
         end
         ST_SHOW: begin
            rsp_valid_in = 1'b1;
            rsp_sel_in   = SEL_W'(scan_pos);
            rsp_seg_in   = store_ff[scan_pos];
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         dwell_ff     <= DWELL_W'(1);
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dwell_ff     <= dwell_in;
         store_ff     <= store_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      wpos_ff    <= wpos_in;
      rsp_sel_ff <= rsp_sel_in;
      rsp_seg_ff <= rsp_seg_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - SEG_W - SEL_W)'(0), rsp_seg_ff, rsp_sel_ff};

endmodule
